// ===== rtl/core/rectangle_region_sum_assert.svh =====
// Assertion macros for the RTL, included by rrs_back. Each expects i_clk and i_rst_n in scope.
`ifndef RECTANGLE_REGION_SUM_ASSERT_SVH
`define RECTANGLE_REGION_SUM_ASSERT_SVH

// Property that holds in the same cycle.
`define RRS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Property that holds in the next cycle.
`define RRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rrs_pkg.sv =====
package rrs_pkg;

    localparam int DIM      = 64;
    localparam int CRD_W    = 6;                          // width of coordinate fields
    localparam int IDX_W    = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int EXT_W    = (CRD_W > IDX_W) ? CRD_W : IDX_W + 1;
    localparam int ADDR_W   = 2 * IDX_W;                  // {row, col}
    localparam int DATA_W   = 32;
    localparam int CQ_DEPTH = 4;
    localparam int CQ_AW    = $clog2(CQ_DEPTH);

    typedef enum logic [0:0] {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        K_LOAD,
        K_QUERY,
        K_ZERO
    } t_kind;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_DRAIN
    } t_bstate;

    // For a load r0/c0 carry row/col; for a query r0/c0 carry top/left and r1/c1 the clamped bottom/right.
    typedef struct packed {
        t_kind              kind;
        logic [IDX_W-1:0]   r0;
        logic [IDX_W-1:0]   c0;
        logic [IDX_W-1:0]   r1;
        logic [IDX_W-1:0]   c1;
        logic [DATA_W-1:0]  value;
        logic               last;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_cq_stat;

    function automatic logic [EXT_W-1:0] crd_ext(input logic [CRD_W-1:0] c);
        crd_ext = EXT_W'(c);
    endfunction

    function automatic logic [IDX_W-1:0] ext_idx(input logic [EXT_W-1:0] e);
        ext_idx = e[IDX_W-1:0];
    endfunction

endpackage

// ===== rtl/core/rrs_front.sv =====
module rrs_front (
    input  logic                            i_operation,
    input  logic [rrs_pkg::CRD_W-1:0]       i_row,
    input  logic [rrs_pkg::CRD_W-1:0]       i_col,
    input  logic signed [rrs_pkg::DATA_W-1:0] i_value,
    input  logic [rrs_pkg::CRD_W-1:0]       i_top,
    input  logic [rrs_pkg::CRD_W-1:0]       i_left,
    input  logic [rrs_pkg::CRD_W-1:0]       i_bottom,
    input  logic [rrs_pkg::CRD_W-1:0]       i_right,
    input  logic                            i_last,
    output logic                            o_keep,
    output rrs_pkg::t_cmd                   o_cmd
);

    localparam int EW = rrs_pkg::EXT_W;
    localparam logic [EW-1:0] DIM_E = EW'(rrs_pkg::DIM);
    localparam logic [EW-1:0] MAX_E = EW'(rrs_pkg::DIM - 1);

    logic [EW-1:0] row_e, col_e, top_e, left_e, bot_e, rgt_e;

    always_comb begin
        row_e  = rrs_pkg::crd_ext(i_row);
        col_e  = rrs_pkg::crd_ext(i_col);
        top_e  = rrs_pkg::crd_ext(i_top);
        left_e = rrs_pkg::crd_ext(i_left);
        bot_e  = rrs_pkg::crd_ext(i_bottom);
        rgt_e  = rrs_pkg::crd_ext(i_right);
        if (bot_e > MAX_E) bot_e = MAX_E;
        if (rgt_e > MAX_E) rgt_e = MAX_E;

        o_cmd.value = i_value;
        o_cmd.last  = i_last;
        o_cmd.r1    = rrs_pkg::ext_idx(bot_e);
        o_cmd.c1    = rrs_pkg::ext_idx(rgt_e);
        o_keep      = 1'b1;
        unique case (rrs_pkg::t_op'(i_operation))
            rrs_pkg::OP_LOAD: begin
                o_cmd.kind = rrs_pkg::K_LOAD;
                o_cmd.r0   = rrs_pkg::ext_idx(row_e);
                o_cmd.c0   = rrs_pkg::ext_idx(col_e);
                // loads outside the matrix are swallowed here
                o_keep     = (row_e < DIM_E) && (col_e < DIM_E);
            end
            rrs_pkg::OP_QUERY: begin
                o_cmd.r0   = rrs_pkg::ext_idx(top_e);
                o_cmd.c0   = rrs_pkg::ext_idx(left_e);
                o_cmd.kind = ((top_e > bot_e) || (left_e > rgt_e)) ? rrs_pkg::K_ZERO
                                                                    : rrs_pkg::K_QUERY;
            end
            default: begin
                o_cmd.kind = rrs_pkg::K_ZERO;
                o_cmd.r0   = '0;
                o_cmd.c0   = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/rrs_cmd_q.sv =====
module rrs_cmd_q (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rrs_pkg::t_cmd       i_cmd,
    input  logic                i_pop,
    output rrs_pkg::t_cmd       o_head,
    output rrs_pkg::t_cq_stat   o_stat
);

    localparam int AW = rrs_pkg::CQ_AW;
    localparam logic [AW:0] DEPTH_C = (AW + 1)'(rrs_pkg::CQ_DEPTH);

    rrs_pkg::t_cmd  r_slot [rrs_pkg::CQ_DEPTH];
    logic [AW-1:0]  r_wp, r_rp, n_wp, n_rp;
    logic [AW:0]    r_cnt, n_cnt;
    logic           do_push, do_pop;

    always_comb begin
        o_stat.full  = (r_cnt == DEPTH_C);
        o_stat.empty = (r_cnt == '0);
        do_push      = i_push && !o_stat.full;
        do_pop       = i_pop && !o_stat.empty;
        n_wp         = do_push ? AW'(r_wp + 1'b1) : r_wp;
        n_rp         = do_pop  ? AW'(r_rp + 1'b1) : r_rp;
        case ({do_push, do_pop})
            2'b10:   n_cnt = (AW + 1)'(r_cnt + 1'b1);
            2'b01:   n_cnt = (AW + 1)'(r_cnt - 1'b1);
            default: n_cnt = r_cnt;
        endcase
        o_head = r_slot[r_rp];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_slot[r_wp] <= i_cmd;
    end

endmodule

// ===== rtl/core/rrs_back.sv =====
module rrs_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rrs_pkg::t_cmd                   i_cmd,
    input  logic                            i_cq_empty,
    output logic                            o_cq_pop,
    input  logic                            i_pop,
    output logic                            o_res_vld,
    output logic signed [rrs_pkg::DATA_W-1:0] o_sum,
    output logic                            o_last
);

    `include "rectangle_region_sum_assert.svh"

    localparam int IW = rrs_pkg::IDX_W;
    localparam int AW = rrs_pkg::ADDR_W;
    localparam int DW = rrs_pkg::DATA_W;

    logic [DW-1:0] r_mem [1 << AW];

    rrs_pkg::t_bstate r_state, n_state;
    logic [IW-1:0]  r_i, r_j, r_c0, r_r1, r_c1;
    logic [IW-1:0]  n_i, n_j, n_c0, n_r1, n_c1;
    logic           r_last, n_last;
    logic [DW-1:0]  r_acc, n_acc;
    logic           r_rd_vld, n_rd_vld;
    logic [DW-1:0]  r_rd_data;
    logic           r_res_vld, n_res_vld;
    logic [DW-1:0]  r_res_sum, n_res_sum;
    logic           r_res_last, n_res_last;
    logic           wr_en, rd_en, slot_free;

    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_j        = r_j;
        n_c0       = r_c0;
        n_r1       = r_r1;
        n_c1       = r_c1;
        n_last     = r_last;
        n_rd_vld   = 1'b0;
        n_acc      = r_acc + (r_rd_vld ? r_rd_data : '0);
        slot_free  = !r_res_vld || i_pop;
        n_res_vld  = r_res_vld && !i_pop;
        n_res_sum  = r_res_sum;
        n_res_last = r_res_last;
        o_cq_pop   = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;

        unique case (r_state)
            rrs_pkg::B_IDLE: begin
                if (!i_cq_empty) begin
                    unique case (i_cmd.kind)
                        rrs_pkg::K_LOAD: begin
                            wr_en    = 1'b1;
                            o_cq_pop = 1'b1;
                        end
                        rrs_pkg::K_ZERO: begin
                            if (slot_free) begin
                                o_cq_pop   = 1'b1;
                                n_res_vld  = 1'b1;
                                n_res_sum  = '0;
                                n_res_last = i_cmd.last;
                            end
                        end
                        rrs_pkg::K_QUERY: begin
                            o_cq_pop = 1'b1;
                            n_i      = i_cmd.r0;
                            n_j      = i_cmd.c0;
                            n_c0     = i_cmd.c0;
                            n_r1     = i_cmd.r1;
                            n_c1     = i_cmd.c1;
                            n_last   = i_cmd.last;
                            n_acc    = '0;
                            n_state  = rrs_pkg::B_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            rrs_pkg::B_SCAN: begin
                rd_en    = 1'b1;
                n_rd_vld = 1'b1;
                if (r_j == r_c1) begin
                    n_j = r_c0;
                    if (r_i == r_r1) n_state = rrs_pkg::B_DRAIN;
                    else n_i = IW'(r_i + 1'b1);
                end else begin
                    n_j = IW'(r_j + 1'b1);
                end
            end
            rrs_pkg::B_DRAIN: begin
                // last read folds into n_acc this cycle; hold there until the slot frees
                if (slot_free) begin
                    n_res_vld  = 1'b1;
                    n_res_sum  = n_acc;
                    n_res_last = r_last;
                    n_state    = rrs_pkg::B_IDLE;
                end
            end
            default: n_state = rrs_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rrs_pkg::B_IDLE;
            r_rd_vld  <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= n_rd_vld;
            r_res_vld <= n_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i        <= n_i;
        r_j        <= n_j;
        r_c0       <= n_c0;
        r_r1       <= n_r1;
        r_c1       <= n_c1;
        r_last     <= n_last;
        r_acc      <= n_acc;
        r_res_sum  <= n_res_sum;
        r_res_last <= n_res_last;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[{i_cmd.r0, i_cmd.c0}] <= i_cmd.value;
        if (rd_en) r_rd_data <= r_mem[{r_i, r_j}];
    end

    assign o_res_vld = r_res_vld;
    assign o_sum     = r_res_sum;
    assign o_last    = r_res_last;

    `RRS_ASSERT_NOW(a_no_pop_busy, r_state != rrs_pkg::B_IDLE, !o_cq_pop, "cmd pop while busy")
    `RRS_ASSERT_NEXT(a_rd_after_scan, r_state != rrs_pkg::B_SCAN, !r_rd_vld, "stray read data")
    `RRS_ASSERT_NOW(a_scan_bounds, r_state == rrs_pkg::B_SCAN, (r_i <= r_r1) && (r_j <= r_c1), "scan out of rectangle")
    `RRS_ASSERT_NEXT(a_res_kept, r_res_vld && !i_pop, r_res_vld && $stable(r_res_sum), "result lost")

endmodule

// ===== rtl/core/rectangle_region_sum.sv =====
// Rectangle sum over a 64 x 64 matrix of signed 32-bit entries.
// Requests enter through a queue-style port: push with full. A load request
// (operation 0) writes one entry at row/col; a query (operation 1) returns the
// wrapped sum of the inclusive rectangle top..bottom, left..right, with last
// copied to o_last_out. Bottom/right saturate to the matrix edge; an empty
// rectangle answers 0. Results leave through empty/pop, oldest first.
// A four-deep command queue sits between the classifying front end and the
// back end, so requests keep being taken while a result waits to be popped.
// Back end: a query scans its rectangle one memory read per cycle; the single
// read port of the matrix memory sets this rate.
// A finished query holds the back end while its result register is still
// occupied, and so does an empty-rectangle query; loads behind either wait in
// the queue. Further pushes stall (full) once the queue fills. Reset empties
// the queues; the matrix is not cleared, so entries must be loaded before a
// query covers them.
module rectangle_region_sum (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              i_operation,
    input  logic [rrs_pkg::CRD_W-1:0]         i_row,
    input  logic [rrs_pkg::CRD_W-1:0]         i_col,
    input  logic signed [rrs_pkg::DATA_W-1:0] i_value,
    input  logic [rrs_pkg::CRD_W-1:0]         i_top,
    input  logic [rrs_pkg::CRD_W-1:0]         i_left,
    input  logic [rrs_pkg::CRD_W-1:0]         i_bottom,
    input  logic [rrs_pkg::CRD_W-1:0]         i_right,
    input  logic                              i_last,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [rrs_pkg::DATA_W-1:0] o_sum,
    output logic                              o_last_out
);

    rrs_pkg::t_cmd     fe_cmd, cq_head;
    rrs_pkg::t_cq_stat cq_stat;
    logic              fe_keep, cq_pop, res_vld;

    rrs_front u_front (
        .i_operation (i_operation),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .i_top       (i_top),
        .i_left      (i_left),
        .i_bottom    (i_bottom),
        .i_right     (i_right),
        .i_last      (i_last),
        .o_keep      (fe_keep),
        .o_cmd       (fe_cmd)
    );

    rrs_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && fe_keep),
        .i_cmd   (fe_cmd),
        .i_pop   (cq_pop),
        .o_head  (cq_head),
        .o_stat  (cq_stat)
    );

    rrs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cq_head),
        .i_cq_empty (cq_stat.empty),
        .o_cq_pop   (cq_pop),
        .i_pop      (pop),
        .o_res_vld  (res_vld),
        .o_sum      (o_sum),
        .o_last     (o_last_out)
    );

    assign full  = cq_stat.full;
    assign empty = !res_vld;

endmodule
